[hw/rtl/ir_pulse_distance_transmitter_defines.svh]
// Assertion helpers for the pulse-distance IR transmitter.
`ifndef IR_PULSE_DISTANCE_TRANSMITTER_DEFINES_SVH
`define IR_PULSE_DISTANCE_TRANSMITTER_DEFINES_SVH

`ifndef SYNTH
`define IRPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("irpd: same-cycle check failed");
`define IRPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("irpd: next-cycle check failed");
`else
`define IRPD_ASSERT_NOW(lbl, ante, cons)
`define IRPD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/irpd_pkg.sv]
package irpd_pkg;

  localparam int CodeBits   = 32;
  localparam int CountWidth = 20;
  localparam int HalfWidth  = 16;
  localparam int BitsWidth  = $clog2(CodeBits);
  localparam int PhaseWidth = 3;
  localparam int CfgIdxWidth = 3;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  // Phase codes
  localparam logic [PhaseWidth-1:0] PhIdle       = 3'd0;
  localparam logic [PhaseWidth-1:0] PhStartMark  = 3'd1;
  localparam logic [PhaseWidth-1:0] PhStartSpace = 3'd2;
  localparam logic [PhaseWidth-1:0] PhBitMark    = 3'd3;
  localparam logic [PhaseWidth-1:0] PhBitSpace   = 3'd4;
  localparam logic [PhaseWidth-1:0] PhStopMark   = 3'd5;
  localparam logic [PhaseWidth-1:0] PhStopSpace  = 3'd6;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CfgHalfPeriod = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgStartTime  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgBitMark    = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgZeroSpace  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgOneSpace   = 3'd4;

  localparam logic [HalfWidth-1:0]  RstHalfPeriod = 16'd1316;
  localparam logic [CountWidth-1:0] RstStartTime  = 20'd460000;
  localparam logic [CountWidth-1:0] RstBitMark    = 20'd56000;
  localparam logic [CountWidth-1:0] RstZeroSpace  = 20'd56000;
  localparam logic [CountWidth-1:0] RstOneSpace   = 20'd169000;

  function automatic logic is_mark(input logic [PhaseWidth-1:0] ph);
    return (ph == PhStartMark) || (ph == PhBitMark) || (ph == PhStopMark);
  endfunction

endpackage

[hw/rtl/irpd_cmd_if.sv]
interface irpd_cmd_if
  import irpd_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [CodeBits-1:0] code;

  modport source (output valid, output cmd, output code, input ready);
  modport sink (input valid, input cmd, input code, output ready);
endinterface

[hw/rtl/irpd_res_if.sv]
interface irpd_res_if;
  logic valid;
  logic ready;
  logic ir_out;
  logic busy_res;
  logic frame_done;
  logic rejected;

  modport source (output valid, output ir_out, output busy_res, output frame_done,
                  output rejected, input ready);
  modport sink (input valid, input ir_out, input busy_res, input frame_done,
                input rejected, output ready);
endinterface

[hw/rtl/irpd_cfg_if.sv]
interface irpd_cfg_if
  import irpd_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CfgIdxWidth-1:0] index;
  logic [CountWidth-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/ir_pulse_distance_transmitter.sv]
// Pulse-distance infrared transmitter with a modulated carrier.
// Channels: cmd_i takes items (cmd = 0 is one timing tick, cmd = 1 sends the
// 32-bit code); res_o returns exactly one result per item (emitter level,
// busy, frame done, send rejected); cfg_i writes the five timing registers
// (carrier half period, start time, bit mark, zero space, one space) and is
// always ready. Write configuration only while no frame is running.
// The result of an item is registered and is on res_o in the cycle after its transfer.
// Throughput: one item per cycle while res_o does not stall; the state update is
// counter increments and compares, so a tick can follow every clock.
// A frame: start mark and start space of start_time ticks, then the code
// bits MSB first (bit_mark mark, zero_space or one_space space), then a
// zero-style stop bit. A send while a frame runs is dropped and flagged.
// Reset (rst_ni low, asynchronous) idles the block, empties the result
// register and loads the default timing values.
// If the receiver stalls, the held result stays on res_o and cmd_i is
// ready only in the cycle the result register is freed.
module ir_pulse_distance_transmitter
  import irpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  irpd_cmd_if.sink   cmd_i,
  irpd_res_if.source res_o,
  irpd_cfg_if.sink   cfg_i
);

`include "ir_pulse_distance_transmitter_defines.svh"

  // Configuration registers
  logic [HalfWidth-1:0]  half_period_q;
  logic [CountWidth-1:0] start_time_q, bit_mark_q, zero_space_q, one_space_q;

  // Transmit state
  logic [PhaseWidth-1:0] phase_q, phase_d;
  logic [BitsWidth-1:0]  bits_q, bits_d;
  logic [CodeBits-1:0]   shift_q, shift_d;
  logic [CountWidth-1:0] span_q, span_d;
  logic [HalfWidth-1:0]  carr_q, carr_d;
  logic                  level_q, level_d;

  // Result register
  logic res_valid_q, res_valid_d;
  logic ir_out_q, busy_q, done_q, rej_q;
  logic ir_out_d, done_d, rej_d;

  logic                  take;
  logic [CountWidth-1:0] span_inc;
  logic [HalfWidth-1:0]  carr_inc;
  logic [CountWidth-1:0] cur_len;
  logic [PhaseWidth-1:0] next_ph;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= RstHalfPeriod;
      start_time_q  <= RstStartTime;
      bit_mark_q    <= RstBitMark;
      zero_space_q  <= RstZeroSpace;
      one_space_q   <= RstOneSpace;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgHalfPeriod: half_period_q <= cfg_i.data[HalfWidth-1:0];
        CfgStartTime:  start_time_q  <= cfg_i.data;
        CfgBitMark:    bit_mark_q    <= cfg_i.data;
        CfgZeroSpace:  zero_space_q  <= cfg_i.data;
        CfgOneSpace:   one_space_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign take        = cmd_i.valid && cmd_i.ready;

  always_comb begin
    case (phase_q)
      PhStartMark, PhStartSpace: cur_len = start_time_q;
      PhBitMark, PhStopMark:     cur_len = bit_mark_q;
      PhBitSpace:                cur_len = shift_q[CodeBits-1] ? one_space_q : zero_space_q;
      default:                   cur_len = zero_space_q;
    endcase
  end

  assign span_inc = (span_q == CountMax) ? span_q : span_q + CountWidth'(1);
  assign carr_inc = carr_q + HalfWidth'(1);

  always_comb begin
    case (phase_q)
      PhStartMark:  next_ph = PhStartSpace;
      PhStartSpace: next_ph = PhBitMark;
      PhBitMark:    next_ph = PhBitSpace;
      PhBitSpace:   next_ph = (bits_q == '0) ? PhStopMark : PhBitMark;
      PhStopMark:   next_ph = PhStopSpace;
      default:      next_ph = PhIdle;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    bits_d  = bits_q;
    shift_d = shift_q;
    span_d  = span_q;
    carr_d  = carr_q;
    level_d = level_q;
    done_d  = 1'b0;
    rej_d   = 1'b0;
    if (take) begin
      if (cmd_i.cmd) begin
        if (phase_q != PhIdle) begin
          rej_d = 1'b1;
        end else begin
          shift_d = cmd_i.code;
          bits_d  = BitsWidth'(CodeBits - 1);
          phase_d = PhStartMark;
          span_d  = '0;
          carr_d  = '0;
          level_d = 1'b1;
        end
      end else if (phase_q != PhIdle) begin
        span_d = span_inc;
        if (is_mark(phase_q)) begin
          if (carr_inc >= half_period_q) begin
            carr_d  = '0;
            level_d = ~level_q;
          end else begin
            carr_d = carr_inc;
          end
        end
        if (span_inc >= cur_len) begin
          // advance to the next phase with counters and carrier restarted
          phase_d = next_ph;
          span_d  = '0;
          carr_d  = '0;
          level_d = is_mark(next_ph);
          if (phase_q == PhBitSpace) begin
            shift_d = {shift_q[CodeBits-2:0], 1'b0};
            if (bits_q != '0) begin
              bits_d = bits_q - BitsWidth'(1);
            end
          end
          if (phase_q == PhStopSpace) begin
            done_d = 1'b1;
          end
        end
      end
    end
  end

  assign ir_out_d    = is_mark(phase_d) && level_d;
  assign res_valid_d = take ? 1'b1 : (res_o.ready ? 1'b0 : res_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      bits_q      <= '0;
      shift_q     <= '0;
      span_q      <= '0;
      carr_q      <= '0;
      level_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      bits_q      <= bits_d;
      shift_q     <= shift_d;
      span_q      <= span_d;
      carr_q      <= carr_d;
      level_q     <= level_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ir_out_q <= ir_out_d;
      busy_q   <= (phase_d != PhIdle);
      done_q   <= done_d;
      rej_q    <= rej_d;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.ir_out     = ir_out_q;
  assign res_o.busy_res   = busy_q;
  assign res_o.frame_done = done_q;
  assign res_o.rejected   = rej_q;

  `IRPD_ASSERT_NOW(a_idle_quiet, phase_q == PhIdle, !level_q && (bits_q == '0))
  `IRPD_ASSERT_NOW(a_span_in_range, phase_q != PhIdle, span_q <= cur_len)
  `IRPD_ASSERT_NEXT(a_busy_send_flagged, take && cmd_i.cmd && (phase_q != PhIdle),
                    res_valid_q && rej_q && busy_q && !done_q)

endmodule

[tb/sv/tb_ir_pulse_distance_transmitter.sv]
`timescale 1ns / 100ps

module tb_ir_pulse_distance_transmitter;
  import irpd_pkg::*;

  localparam int HalfClk       = 6;
  localparam int ResetCycles   = 10;
  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 4000;
  localparam int RandomItems   = 60;

  typedef struct packed {
    logic ir_out;
    logic busy;
    logic done;
    logic rejected;
  } emitter_res_t;

  logic clk_i;
  logic rst_ni;

  irpd_cmd_if cmd_if ();
  irpd_res_if res_if ();
  irpd_cfg_if cfg_if ();

  ir_pulse_distance_transmitter u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always begin
    clk_i = 1'b0;
    #HalfClk;
    clk_i = 1'b1;
    #HalfClk;
  end

  // Timing registers as the emitter should hold them
  logic [HalfWidth-1:0]  cfg_half;
  logic [CountWidth-1:0] cfg_start;
  logic [CountWidth-1:0] cfg_mark;
  logic [CountWidth-1:0] cfg_zero;
  logic [CountWidth-1:0] cfg_one;

  // Frame state of the emitter
  logic [PhaseWidth-1:0] tx_phase;
  logic [5:0]            tx_bits_left;
  logic [CodeBits-1:0]   tx_word;
  logic [CountWidth-1:0] tx_span;
  logic [HalfWidth-1:0]  tx_carrier_cnt;
  logic                  tx_carrier;

  emitter_res_t emitter_expect_q[$];

  int   err_count   = 0;
  int   busy_items  = 0;
  int   gap_pct     = 0;
  int   stall_pct   = 0;
  int   hold_left   = 0;
  int   idle_cycles = 0;
  logic hold_req    = 1'b0;

  function automatic logic mark_phase(input logic [PhaseWidth-1:0] ph);
    return ph inside {PhStartMark, PhBitMark, PhStopMark};
  endfunction

  function automatic void enter_phase(input logic [PhaseWidth-1:0] nxt);
    tx_phase       = nxt;
    tx_span        = '0;
    tx_carrier_cnt = '0;
    tx_carrier     = mark_phase(nxt);
  endfunction

  function automatic logic [CountWidth-1:0] span_limit();
    case (tx_phase)
      PhStartMark, PhStartSpace: return cfg_start;
      PhBitMark, PhStopMark:     return cfg_mark;
      PhBitSpace:                return tx_word[CodeBits-1] ? cfg_one : cfg_zero;
      default:                   return cfg_zero;
    endcase
  endfunction

  function automatic emitter_res_t predict_emitter(input logic send,
                                                   input logic [CodeBits-1:0] word);
    emitter_res_t r;
    r = '0;
    if (send) begin
      if (tx_phase != PhIdle) begin
        r.rejected = 1'b1;
      end else begin
        tx_word      = word;
        tx_bits_left = 6'(CodeBits - 1);
        enter_phase(PhStartMark);
      end
    end else if (tx_phase != PhIdle) begin
      if (tx_span != CountMax) tx_span = tx_span + CountWidth'(1);
      if (mark_phase(tx_phase)) begin
        tx_carrier_cnt = tx_carrier_cnt + HalfWidth'(1);
        if (tx_carrier_cnt >= cfg_half) begin
          tx_carrier_cnt = '0;
          tx_carrier     = ~tx_carrier;
        end
      end
      if (tx_span >= span_limit()) begin
        case (tx_phase)
          PhStartMark:  enter_phase(PhStartSpace);
          PhStartSpace: enter_phase(PhBitMark);
          PhBitMark:    enter_phase(PhBitSpace);
          PhBitSpace: begin
            tx_word = tx_word << 1;
            if (tx_bits_left == '0) begin
              enter_phase(PhStopMark);
            end else begin
              tx_bits_left = tx_bits_left - 6'(1);
              enter_phase(PhBitMark);
            end
          end
          PhStopMark: enter_phase(PhStopSpace);
          default: begin
            enter_phase(PhIdle);
            r.done = 1'b1;
          end
        endcase
      end
    end
    r.ir_out = mark_phase(tx_phase) & tx_carrier;
    r.busy   = (tx_phase != PhIdle);
    return r;
  endfunction

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      err_count++;
      $display("%0t ns: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    emitter_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (emitter_expect_q.size() == 0) begin
        err_count++;
        $display("%0t ns: result with none expected, actual ir_out %0b busy %0b done %0b rej %0b",
                 $time, res_if.ir_out, res_if.busy_res, res_if.frame_done, res_if.rejected);
      end else begin
        want = emitter_expect_q.pop_front();
        check_field("ir_out", want.ir_out, res_if.ir_out);
        check_field("busy_res", want.busy, res_if.busy_res);
        check_field("frame_done", want.done, res_if.frame_done);
        check_field("rejected", want.rejected, res_if.rejected);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req     <= 1'b0;
      hold_left    <= HoldCycles;
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("** ir_pulse_distance_transmitter: FAILED **");
      $finish;
    end
  end

  task automatic send_item(input logic send, input logic [CodeBits-1:0] word);
    emitter_res_t r;
    while ($urandom_range(0, 99) < gap_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.cmd   <= send;
    cmd_if.code  <= word;
    do @(posedge clk_i); while (!cmd_if.ready);
    r = predict_emitter(send, word);
    emitter_expect_q.push_back(r);
    if (r.busy || r.done) busy_items++;
  endtask

  // Hold the sender until every result is back
  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (emitter_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CountWidth-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CfgHalfPeriod: cfg_half  = data[HalfWidth-1:0];
      CfgStartTime:  cfg_start = data;
      CfgBitMark:    cfg_mark  = data;
      CfgZeroSpace:  cfg_zero  = data;
      CfgOneSpace:   cfg_one   = data;
      default: ;
    endcase
  endtask

  task automatic load_timing(input logic [CountWidth-1:0] half,
                             input logic [CountWidth-1:0] start,
                             input logic [CountWidth-1:0] mark,
                             input logic [CountWidth-1:0] zero,
                             input logic [CountWidth-1:0] one,
                             input logic spare);
    drain();
    write_reg(CfgHalfPeriod, half);
    write_reg(CfgStartTime, start);
    write_reg(CfgBitMark, mark);
    write_reg(CfgZeroSpace, zero);
    write_reg(CfgOneSpace, one);
    // unused indexes must leave the timing alone
    if (spare) begin
      for (int i = int'(CfgOneSpace) + 1; i < (1 << CfgIdxWidth); i++)
        write_reg(CfgIdxWidth'(i), CountWidth'($urandom()));
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Tick until the frame ends, with the odd send that must bounce
  task automatic finish_frame(input int reject_pct);
    while (tx_phase != PhIdle) begin
      if ($urandom_range(0, 99) < reject_pct) send_item(1'b1, $urandom());
      else send_item(1'b0, $urandom());
    end
  endtask

  task automatic test_idle_ticks();
    gap_pct = 0;
    stall_pct <= 0;
    repeat (3) send_item(1'b0, $urandom());
    drain();
  endtask

  task automatic test_directed_frames();
    load_timing(20'h0_0001, 20'd3, 20'd3, 20'd1, 20'd2, 1'b0);
    send_item(1'b1, '1);
    send_item(1'b1, '0);
    finish_frame(0);
    send_item(1'b0, '1);
    send_item(1'b1, '0);
    finish_frame(0);
    send_item(1'b1, {1'b1, {(CodeBits - 2){1'b0}}, 1'b1});
    finish_frame(10);
    // zero durations and half period behave as one
    load_timing(20'hF_0000, '0, '0, '0, '0, 1'b1);
    send_item(1'b1, 32'hA5C3_5A3C);
    finish_frame(10);
  endtask

  // Largest half period and a long stop space
  task automatic test_register_extremes();
    gap_pct = 0;
    stall_pct <= 0;
    load_timing(20'h0_FFFF, 20'd1, 20'd1, 20'd64, 20'd1, 1'b0);
    send_item(1'b1, '1);
    finish_frame(0);
  endtask

  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct <= 0;
    load_timing(20'd1, 20'd2, 20'd2, 20'd1, 20'd2, 1'b0);
    send_item(1'b1, $urandom());
    hold_req <= 1'b1;
    finish_frame(0);
    drain();
  endtask

  task automatic test_random_frames(input int gap, input int stall);
    logic [CodeBits-1:0] word;
    gap_pct = gap;
    stall_pct <= stall;
    busy_items = 0;
    while (busy_items < RandomItems) begin
      if ($urandom_range(0, 1) == 0) begin
        load_timing({4'($urandom()), 16'($urandom_range(0, 3))},
                    CountWidth'($urandom_range(0, 3)), CountWidth'($urandom_range(0, 4)),
                    CountWidth'($urandom_range(0, 2)), CountWidth'($urandom_range(0, 3)),
                    $urandom_range(0, 7) == 0);
      end
      repeat ($urandom_range(0, 2)) send_item(1'b0, $urandom());
      case ($urandom_range(0, 4))
        0:       word = '0;
        1:       word = '1;
        2:       word = CodeBits'(1) << $urandom_range(0, CodeBits - 1);
        default: word = $urandom();
      endcase
      send_item(1'b1, word);
      finish_frame(4);
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.cmd   = 1'b0;
    cmd_if.code  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CfgHalfPeriod;
    cfg_if.data  = '0;
    res_if.ready = 1'b0;

    cfg_half       = RstHalfPeriod;
    cfg_start      = RstStartTime;
    cfg_mark       = RstBitMark;
    cfg_zero       = RstZeroSpace;
    cfg_one        = RstOneSpace;
    tx_phase       = PhIdle;
    tx_bits_left   = '0;
    tx_word        = '0;
    tx_span        = '0;
    tx_carrier_cnt = '0;
    tx_carrier     = 1'b0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_idle_ticks();
    test_directed_frames();
    test_register_extremes();
    test_backpressure();
    test_random_frames(0, 0);
    test_random_frames(75, 0);
    test_random_frames(0, 75);
    test_random_frames(19, 19);

    drain();
    repeat (4) @(posedge clk_i);
    if (err_count == 0) begin
      $display("** ir_pulse_distance_transmitter: PASSED **");
    end else begin
      $display("** ir_pulse_distance_transmitter: FAILED **");
    end
    $finish;
  end

endmodule

[ir_pulse_distance_transmitter.f]
+incdir+hw/rtl
hw/rtl/irpd_pkg.sv
hw/rtl/irpd_cmd_if.sv
hw/rtl/irpd_res_if.sv
hw/rtl/irpd_cfg_if.sv
hw/rtl/ir_pulse_distance_transmitter.sv
tb/sv/tb_ir_pulse_distance_transmitter.sv
